### hw/rtl/float_lower_bound_search_macros.svh
// Assertion macros for the lower bound search block.
`ifndef FLOAT_LOWER_BOUND_SEARCH_MACROS_SVH
`define FLOAT_LOWER_BOUND_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define FLBS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FLBS_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FLBS_ASSERT(label, clk, rst_n, prop, msg)
`define FLBS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### hw/rtl/flbs_pkg.sv
package flbs_pkg;
	localparam int TABLE_DEPTH = 256;
	localparam int MAX_LEVELS = 8;
	localparam int VAL_W = 32;
	localparam int LB_W = 8;
	localparam int LVL_W = 4;
	localparam logic [LVL_W-1:0] LEVELS_RESET = 4'd8;
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic load;
		logic write;
		logic rd;
		logic step;
	} flbs_cmd_t;

	typedef struct packed {
		logic last;
		logic in_range;
	} flbs_sts_t;

	function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] v);
		return v[VAL_W-1] ? ~v : (v | {1'b1, {(VAL_W-1){1'b0}}});
	endfunction

	function automatic logic is_nan(input logic [VAL_W-1:0] v);
		return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
	endfunction

	function automatic logic float_less(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		if (is_nan(a) || is_nan(b))
			return 1'b0;
		if (((a | b) & 32'h7FFF_FFFF) == 32'd0)
			return 1'b0;
		return order_key(a) < order_key(b);
	endfunction
endpackage

### hw/rtl/float_lower_bound_search.sv
// channel   direction  handshake                  payload
// in        input      in_valid / in_ready        action entry_index entry_value search_key
// out       output     out_valid / out_ready      below_count
// cfg       input      cfg_we (no wait)           cfg_data = search_levels
// A write word is stored without leaving idle; a search reads and then compares once per
// halving step through the single registered table read port.
// Reset clears control and sets search_levels to 8; table contents stay undefined.
// A finished result holds until out_ready; no new word is taken meanwhile.
`include "float_lower_bound_search_macros.svh"
module float_lower_bound_search #(
	parameter int TABLE_DEPTH = flbs_pkg::TABLE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [7:0]                     entry_index,
	input  logic [flbs_pkg::VAL_W-1:0]     entry_value,
	input  logic [flbs_pkg::VAL_W-1:0]     search_key,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [flbs_pkg::LB_W-1:0]      below_count,
	input  logic                           cfg_we,
	input  logic [flbs_pkg::LVL_W-1:0]     cfg_data
);
	logic [flbs_pkg::LVL_W-1:0] levels_q;
	flbs_pkg::flbs_cmd_t cmd;
	flbs_pkg::flbs_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			levels_q <= flbs_pkg::LEVELS_RESET;
		else if (cfg_we)
			levels_q <= cfg_data;
	end

	flbs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	flbs_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .levels(levels_q),
		.entry_index(entry_index), .entry_value(entry_value),
		.search_key(search_key), .below_count(below_count)
	);

	`FLBS_ASSERT(a_no_ready_while_out, clk, arst_n, out_valid |-> !in_ready, "ready during result")
	`FLBS_ASSERT(a_search_no_out_next, clk, arst_n, (in_valid && in_ready && action) |=> !out_valid, "early result")
	`FLBS_ASSERT(a_out_holds, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(below_count)), "result dropped")
	`FLBS_ASSERT(a_cmd_excl, clk, arst_n, $onehot0({cmd.load, cmd.write, cmd.rd, cmd.step}), "command clash")
endmodule

### hw/rtl/flbs_ram.sv
module flbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

### hw/rtl/flbs_datapath.sv
module flbs_datapath #(
	parameter int TABLE_DEPTH = flbs_pkg::TABLE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  flbs_pkg::flbs_cmd_t            cmd,
	output flbs_pkg::flbs_sts_t            sts,
	input  logic [flbs_pkg::LVL_W-1:0]     levels,
	input  logic [7:0]                     entry_index,
	input  logic [flbs_pkg::VAL_W-1:0]     entry_value,
	input  logic [flbs_pkg::VAL_W-1:0]     search_key,
	output logic [flbs_pkg::LB_W-1:0]      below_count
);
	localparam int AW = $clog2(TABLE_DEPTH);
	// largest k with 2^k-1 <= TABLE_DEPTH, capped at MAX_LEVELS
	localparam int KMAX_RAW = $clog2(TABLE_DEPTH + 2) - 1;
	localparam int KMAX = (KMAX_RAW > flbs_pkg::MAX_LEVELS) ? flbs_pkg::MAX_LEVELS : KMAX_RAW;

	logic [flbs_pkg::VAL_W-1:0] key_q;
	logic [8:0] base_q, step_q, probe;
	logic [flbs_pkg::VAL_W-1:0] rdata;
	logic [3:0] k;
	logic pend_q;

	always_comb begin
		k = (levels > 4'(KMAX)) ? 4'(KMAX) : levels;
		probe = base_q + step_q - 9'd1;
	end

	flbs_ram #(.WIDTH(flbs_pkg::VAL_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk),
		.we(cmd.write && (17'(entry_index) < 17'(TABLE_DEPTH))),
		.waddr(AW'(entry_index)),
		.wdata(entry_value),
		.re(cmd.rd),
		.raddr(AW'(probe)),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			step_q <= '0;
			pend_q <= 1'b0;
		end else if (cmd.load) begin
			base_q <= '0;
			step_q <= (k == 4'd0) ? 9'd0 : (9'd1 << (k - 4'd1));
			pend_q <= 1'b0;
		end else if (cmd.rd) begin
			pend_q <= (17'(probe) < 17'(TABLE_DEPTH));
		end else if (cmd.step) begin
			if (pend_q && flbs_pkg::float_less(rdata, key_q))
				base_q <= base_q + step_q;
			step_q <= step_q >> 1;
		end
	end

	always_ff @(posedge clk)
		if (cmd.load)
			key_q <= search_key;

	assign sts.last = (step_q <= 9'd1);
	assign sts.in_range = (step_q != 9'd0);
	assign below_count = base_q[7:0];
endmodule

### hw/rtl/flbs_ctrl.sv
module flbs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	output logic                out_valid,
	input  logic                out_ready,
	output flbs_pkg::flbs_cmd_t cmd,
	input  flbs_pkg::flbs_sts_t sts
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_CMP  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic take;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign take = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					cmd.write = (action == flbs_pkg::ACT_WRITE);
					cmd.load = (action == flbs_pkg::ACT_SEARCH);
					if (action == flbs_pkg::ACT_SEARCH)
						state_d = S_RD;
				end
			end
			S_RD: begin
				if (sts.in_range) begin
					cmd.rd = 1'b1;
					state_d = S_CMP;
				end else
					state_d = S_OUT;
			end
			S_CMP: begin
				cmd.step = 1'b1;
				state_d = sts.last ? S_OUT : S_RD;
			end
			S_OUT: begin
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule
